// ===== rtl/dual_stack_shared_pool_defines.svh =====
// Assertion macros for the two-stack shared pool block.
// Included by every RTL file that carries concurrent assertions.
// No dependencies.
`ifndef DUAL_STACK_SHARED_POOL_DEFINES_SVH
`define DUAL_STACK_SHARED_POOL_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DSSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dssp: assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define DSSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dssp: implication failed");
`else
`define DSSP_ASSERT(label, clk, rst_n, prop)
`define DSSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/dssp_pkg.sv =====
// Shared types and codes for the two-stack shared pool block.
// No dependencies; used by dssp_stack, dssp_pool and the top level.
package dssp_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_A = 2'd0,
        MODE_POP_A  = 2'd1,
        MODE_PUSH_B = 2'd2,
        MODE_POP_B  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

    typedef struct packed {
        logic alloc;
        logic dealloc;
    } pool_ctrl_t;

endpackage

// ===== rtl/dssp_stack.sv =====
// One stack of slot numbers: register array plus entry count.
// Depends on dssp_pkg.
module dssp_stack #(
    parameter int  DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dssp_pkg::stk_ctrl_t   ctrl,
    input  logic [IDX_W-1:0]      push_slot,
    output logic [IDX_W-1:0]      top_slot,
    output logic [CNT_W-1:0]      count,
    output logic                  empty
);

    logic [IDX_W-1:0] slots_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] top_idx;

    assign top_idx  = count_reg - CNT_W'(1);
    assign top_slot = slots_reg[top_idx[IDX_W-1:0]];
    assign count    = count_reg;
    assign empty    = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Slot list needs no reset: only entries below the count are read.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            slots_reg[count_reg[IDX_W-1:0]] <= push_slot;
        end
    end

endmodule

// ===== rtl/dssp_pool.sv =====
// Shared slot pool: data slots, used map, lowest-free search and use count.
// Depends on dssp_pkg and dual_stack_shared_pool_defines.svh.
`include "dual_stack_shared_pool_defines.svh"

module dssp_pool #(
    parameter int  DEPTH      = 16,
    parameter int  DATA_WIDTH = 32,
    localparam int IDX_W      = $clog2(DEPTH),
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dssp_pkg::pool_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0]  wr_data,
    input  logic [IDX_W-1:0]       pop_slot,
    output logic [IDX_W-1:0]       free_slot,
    output logic [DATA_WIDTH-1:0]  rd_data,
    output logic                   full,
    output logic [CNT_W-1:0]       used_cnt
);

    logic [DATA_WIDTH-1:0] data_mem [DEPTH];
    logic [DEPTH-1:0]      used_reg;
    logic [DEPTH-1:0]      used_next;
    logic [CNT_W-1:0]      used_cnt_reg;
    logic [CNT_W-1:0]      used_cnt_next;

    // Priority encoder: lowest slot whose used bit is clear.
    always_comb
    begin
        free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    assign rd_data  = data_mem[pop_slot];
    assign full     = (used_cnt_reg == CNT_W'(DEPTH));
    assign used_cnt = used_cnt_reg;

    always_comb
    begin
        used_next     = used_reg;
        used_cnt_next = used_cnt_reg;
        if (ctrl.alloc)
        begin
            used_next[free_slot] = 1'b1;
            used_cnt_next        = used_cnt_reg + CNT_W'(1);
        end
        else if (ctrl.dealloc)
        begin
            used_next[pop_slot] = 1'b0;
            used_cnt_next       = used_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            used_cnt_reg <= '0;
        end
        else
        begin
            used_reg     <= used_next;
            used_cnt_reg <= used_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.alloc)
        begin
            data_mem[free_slot] <= wr_data;
        end
    end

    `DSSP_ASSERT(used_cnt_matches_map, clk, rst_n, $countones(used_reg) == int'(used_cnt_reg))
    `DSSP_ASSERT_IMP(alloc_only_free, clk, rst_n, ctrl.alloc, !full && !used_reg[free_slot])
    `DSSP_ASSERT_IMP(dealloc_only_used, clk, rst_n, ctrl.dealloc, used_reg[pop_slot])

endmodule

// ===== rtl/dual_stack_shared_pool.sv =====
// Top level: input register, push/pop control over two stacks and the pool,
// result register. Depends on dssp_pkg, dssp_stack, dssp_pool and the defines.
`include "dual_stack_shared_pool_defines.svh"

// The input register holds each transferred item; the result register takes it
// once empty or being drained. Throughput: one item per cycle unless the output
// stalls; the path from the used map through the lowest-free priority encoder
// (POOL_SLOTS entries) to the pool sets the clock.
// Reset (rst_n low, asynchronous) empties both stacks and frees every slot;
// the block takes items in the first cycle after reset, no clearing pass.
module dual_stack_shared_pool #(
    parameter int POOL_SLOTS = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_out
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam int EXT_W = 64;

    logic                           in_valid_reg;
    dssp_pkg::mode_t                in_mode_reg;
    logic [dssp_pkg::VALUE_W-1:0]   in_value_reg;

    logic                           out_valid_reg;
    logic [dssp_pkg::VALUE_W-1:0]   out_value_reg;
    logic [dssp_pkg::VALUE_W-1:0]   out_value_next;
    dssp_pkg::status_t              out_status_reg;
    dssp_pkg::status_t              out_status_next;

    logic                           advance;
    dssp_pkg::stk_ctrl_t            a_ctrl;
    dssp_pkg::stk_ctrl_t            b_ctrl;
    dssp_pkg::pool_ctrl_t           p_ctrl;
    logic [IDX_W-1:0]               a_top;
    logic [IDX_W-1:0]               b_top;
    logic [CNT_W-1:0]               a_count;
    logic [CNT_W-1:0]               b_count;
    logic                           a_empty;
    logic                           b_empty;
    logic [IDX_W-1:0]               free_slot;
    logic [IDX_W-1:0]               pop_slot;
    logic                           pool_full;
    logic [CNT_W-1:0]               used_cnt;
    logic [CNT_W:0]                 cnt_sum;
    logic [DATA_WIDTH-1:0]          wr_data;
    logic [DATA_WIDTH-1:0]          rd_data;
    logic [EXT_W-1:0]               in_wide;
    logic [EXT_W-1:0]               rd_wide;

    // Move the held item into the result register when that register frees up.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    // Sign-extend the input so a wide pool keeps its sign; store low DATA_WIDTH bits.
    assign in_wide = {{(EXT_W - dssp_pkg::VALUE_W){in_value_reg[dssp_pkg::VALUE_W-1]}},
                      in_value_reg};
    assign wr_data = in_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        for (int i = 0; i < EXT_W; i++)
        begin
            rd_wide[i] = rd_data[(i < DATA_WIDTH) ? i : DATA_WIDTH - 1];
        end
    end

    assign pop_slot = (in_mode_reg == dssp_pkg::MODE_POP_B) ? b_top : a_top;

    always_comb
    begin
        a_ctrl          = '0;
        b_ctrl          = '0;
        p_ctrl          = '0;
        out_value_next  = '0;
        out_status_next = dssp_pkg::ST_OK;
        case (in_mode_reg)
            dssp_pkg::MODE_PUSH_A:
            begin
                if (pool_full)
                begin
                    out_status_next = dssp_pkg::ST_FULL;
                end
                else
                begin
                    a_ctrl.push  = advance;
                    p_ctrl.alloc = advance;
                end
            end
            dssp_pkg::MODE_POP_A:
            begin
                if (a_empty)
                begin
                    out_status_next = dssp_pkg::ST_EMPTY;
                end
                else
                begin
                    a_ctrl.pop     = advance;
                    p_ctrl.dealloc = advance;
                    out_value_next = rd_wide[dssp_pkg::VALUE_W-1:0];
                end
            end
            dssp_pkg::MODE_PUSH_B:
            begin
                if (pool_full)
                begin
                    out_status_next = dssp_pkg::ST_FULL;
                end
                else
                begin
                    b_ctrl.push  = advance;
                    p_ctrl.alloc = advance;
                end
            end
            dssp_pkg::MODE_POP_B:
            begin
                if (b_empty)
                begin
                    out_status_next = dssp_pkg::ST_EMPTY;
                end
                else
                begin
                    b_ctrl.pop     = advance;
                    p_ctrl.dealloc = advance;
                    out_value_next = rd_wide[dssp_pkg::VALUE_W-1:0];
                end
            end
            default:
            begin
                out_status_next = dssp_pkg::ST_OK;
            end
        endcase
    end

    dssp_stack #(
        .DEPTH (POOL_SLOTS)
    ) u_stack_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (a_ctrl),
        .push_slot (free_slot),
        .top_slot  (a_top),
        .count     (a_count),
        .empty     (a_empty)
    );

    dssp_stack #(
        .DEPTH (POOL_SLOTS)
    ) u_stack_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (b_ctrl),
        .push_slot (free_slot),
        .top_slot  (b_top),
        .count     (b_count),
        .empty     (b_empty)
    );

    dssp_pool #(
        .DEPTH      (POOL_SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (p_ctrl),
        .wr_data   (wr_data),
        .pop_slot  (pop_slot),
        .free_slot (free_slot),
        .rd_data   (rd_data),
        .full      (pool_full),
        .used_cnt  (used_cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg  <= dssp_pkg::mode_t'(s_axis_tuser);
            in_value_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign cnt_sum = {1'b0, a_count} + {1'b0, b_count};

    `DSSP_ASSERT(counts_sum_to_used, clk, rst_n, (cnt_sum == {1'b0, used_cnt}))
    `DSSP_ASSERT_IMP(stall_only_when_blocked, clk, rst_n, !s_axis_tready,
                     in_valid_reg && out_valid_reg && !m_axis_tready)
    `DSSP_ASSERT_IMP(one_stack_per_item, clk, rst_n, a_ctrl.push || a_ctrl.pop,
                     !b_ctrl.push && !b_ctrl.pop)

endmodule
